@@ rtl/assert_macros.svh @@
// assert_macros.svh: assertion helpers for the stream pattern masker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, off while in reset
`define SMK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never hold
`define SMK_NEVER(label, cond, msg) \
  `SMK_ASSERT(label, !(cond), msg)

`endif

@@ rtl/smk_pkg.sv @@
// smk_pkg: types and constants of the stream pattern masker.
// No dependencies; used by all modules under rtl.
package smk_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] STAR_BYTE = 8'd42;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]      eff_len;
  } cfg_t;

endpackage

@@ rtl/smk_cfg.sv @@
// smk_cfg: pattern configuration registers and clamped pattern length.
// Depends on smk_pkg.
module smk_cfg #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [smk_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output smk_pkg::cfg_t                    cfg_o
);

  localparam int unsigned LW = smk_pkg::LEN_W;

  logic [smk_pkg::CFG_DATA_W-1:0] pattern_q;
  logic [LW-1:0]                  len_q;
  logic [LW-1:0]                  eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        smk_pkg::CFG_PATTERN_BYTES:  pattern_q <= cfg_wdata_i;
        smk_pkg::CFG_PATTERN_LENGTH: len_q     <= cfg_wdata_i[LW-1:0];
      endcase
    end
  end

  always_comb begin
    eff_len = len_q;
    if (len_q == '0) begin
      eff_len = LW'(1);
    end else if (len_q > LW'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end
  end

  assign cfg_o.pattern_bytes = pattern_q;
  assign cfg_o.eff_len       = eff_len;

endmodule

@@ rtl/smk_step.sv @@
// smk_step: one decision on the pending window: star, passed byte or flush byte.
// Depends on smk_pkg.
module smk_step #(
  parameter int unsigned MAX_PATTERN = 8,
  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1)
) (
  input  logic [7:0]                      win_i [MAX_PATTERN],
  input  logic [FILL_W-1:0]               fill_i,
  input  logic [FILL_W-1:0]               stars_i,
  input  logic                            eos_i,
  input  smk_pkg::cfg_t                   cfg_i,
  output logic [7:0]                      win_o [MAX_PATTERN],
  output logic [FILL_W-1:0]               fill_o,
  output logic [FILL_W-1:0]               stars_o,
  output logic [7:0]                      byte_o,
  output logic                            more_o
);

  localparam int unsigned LW = smk_pkg::LEN_W;

  logic          hit;
  logic [LW-1:0] fill_w;
  logic [LW-1:0] fill_nw;

  assign fill_w  = LW'(fill_i);
  assign fill_nw = LW'(fill_o);

  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LW'(k) < cfg_i.eff_len && win_i[k] != cfg_i.pattern_bytes[8*k +: 8]) begin
        hit = 1'b0;
      end
    end

    // drop the oldest byte
    for (int k = 0; k < MAX_PATTERN - 1; k++) begin
      win_o[k] = win_i[k+1];
    end
    win_o[MAX_PATTERN-1] = win_i[MAX_PATTERN-1];
    fill_o = (fill_i != '0) ? fill_i - FILL_W'(1) : '0;

    byte_o  = win_i[0];
    stars_o = '0;
    if (stars_i != '0) begin
      byte_o  = smk_pkg::STAR_BYTE;
      stars_o = stars_i - FILL_W'(1);
    end else if (fill_w >= cfg_i.eff_len && hit) begin
      byte_o  = smk_pkg::STAR_BYTE;
      stars_o = FILL_W'(cfg_i.eff_len - LW'(1));
    end
  end

  assign more_o = (stars_o != '0) || (fill_nw >= cfg_i.eff_len) || (eos_i && fill_o != '0);

endmodule

@@ rtl/stream_pattern_masker.sv @@
// stream_pattern_masker: replaces each leftmost non-overlapping pattern hit by stars.
// Depends on smk_pkg, smk_cfg, smk_step and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o  | smk_pkg::in_item_t
//  out     | output    | out_valid_o/out_stall_i| smk_pkg::out_item_t
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One result per cycle while out_stall_i is low; an item leading to no match lets bytes
// stream at one per cycle. A hit of L bytes gives L stars, one a cycle from the
// output register while out_stall_i is low, and the input stalls until the run ends.
// Each item passes the input register, then the output register, before it transfers out.
// Reset is asynchronous; it empties the window and loads the default pattern.
`include "assert_macros.svh"

module stream_pattern_masker #(
  parameter int unsigned MAX_PATTERN = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  smk_pkg::in_item_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output smk_pkg::out_item_t               out_data_o,
  input  logic                             cfg_we_i,
  input  logic [smk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [smk_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LW     = smk_pkg::LEN_W;

  smk_pkg::cfg_t      cfg;
  smk_pkg::in_item_t  in_q;
  smk_pkg::out_item_t out_q;
  logic               in_vld_q, out_vld_q, run_q, eos_q;
  logic [FILL_W-1:0]  fill_q, stars_q;
  logic [7:0]         win_q [MAX_PATTERN];

  logic [7:0]         win_a [MAX_PATTERN];
  logic [FILL_W-1:0]  fill_a;
  logic [7:0]         src_win [MAX_PATTERN];
  logic [FILL_W-1:0]  src_fill, src_stars;
  logic               src_eos;
  logic [7:0]         stp_win [MAX_PATTERN];
  logic [FILL_W-1:0]  stp_fill, stp_stars;
  logic [7:0]         stp_byte;
  logic               stp_more;
  logic               out_free, need_step, do_step, in_take, in_xfer;

  smk_cfg #(.MAX_PATTERN(MAX_PATTERN)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // append the held input byte behind the pending ones
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_a[k] = win_q[k];
      if (FILL_W'(k) == fill_q) begin
        win_a[k] = in_q.data_byte;
      end
    end
    fill_a = (fill_q < FILL_W'(MAX_PATTERN)) ? fill_q + FILL_W'(1) : fill_q;
  end

  always_comb begin
    if (run_q) begin
      src_win   = win_q;
      src_fill  = fill_q;
      src_stars = stars_q;
      src_eos   = eos_q;
    end else begin
      src_win   = win_a;
      src_fill  = fill_a;
      src_stars = '0;
      src_eos   = in_q.end_of_stream;
    end
  end

  smk_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
    .win_i   (src_win),
    .fill_i  (src_fill),
    .stars_i (src_stars),
    .eos_i   (src_eos),
    .cfg_i   (cfg),
    .win_o   (stp_win),
    .fill_o  (stp_fill),
    .stars_o (stp_stars),
    .byte_o  (stp_byte),
    .more_o  (stp_more)
  );

  assign out_free  = !out_vld_q || !out_stall_i;
  assign need_step = run_q ||
                     (in_vld_q && (LW'(fill_a) >= cfg.eff_len || in_q.end_of_stream));
  assign do_step   = need_step && out_free;
  assign in_take   = !run_q && in_vld_q && (!need_step || out_free);
  assign in_stall_o = in_vld_q && !in_take;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      run_q     <= 1'b0;
      eos_q     <= 1'b0;
      fill_q    <= '0;
      stars_q   <= '0;
    end else begin
      in_vld_q <= in_xfer || (in_vld_q && !in_take);
      if (do_step) begin
        run_q   <= stp_more;
        eos_q   <= src_eos;
        fill_q  <= stp_fill;
        stars_q <= stp_stars;
      end else if (in_take) begin
        run_q   <= 1'b0;
        eos_q   <= in_q.end_of_stream;
        fill_q  <= fill_a;
        stars_q <= '0;
      end
      if (do_step) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (do_step) begin
      win_q <= stp_win;
      out_q <= '{out_byte: stp_byte, last_of_run: !stp_more,
                 stream_done: !stp_more && src_eos};
    end else if (in_take) begin
      win_q <= win_a;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `SMK_NEVER(a_fill_bound, fill_q > FILL_W'(MAX_PATTERN), "window fill beyond depth")
  `SMK_ASSERT(a_stars_run, (stars_q != '0) |-> run_q, "stars pending outside a run")
  `SMK_ASSERT(a_no_take_in_run, run_q |-> !in_take, "input taken during a run")
  `SMK_ASSERT(a_last_ends_run, do_step |=> (out_q.last_of_run == !run_q),
              "last_of_run out of step with run state")
  `SMK_ASSERT(a_done_is_last, (out_vld_q && out_q.stream_done) |-> out_q.last_of_run,
              "stream_done without last_of_run")

endmodule

@@ sim/stream_pattern_masker_test.sv @@
// stream_pattern_masker_test: self-checking testbench for stream_pattern_masker.
// Predicts the masked byte stream per transfer and compares it with the output channel.
// Depends on smk_pkg and the RTL under rtl.
module stream_pattern_masker_test;

  localparam int unsigned WIN_DEPTH    = 8;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES   = 100;
  localparam int unsigned RUN_LIMIT     = 200_000;
  localparam int unsigned PRINT_CAP     = 60;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  smk_pkg::in_item_t              in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  smk_pkg::out_item_t             out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [smk_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = smk_pkg::CFG_PATTERN_BYTES;
  logic [smk_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // predictor state
  logic [63:0]         pat_bytes   = '0;
  logic [3:0]          pat_len_reg = 4'd1;
  logic [7:0]          win_bytes [WIN_DEPTH];
  int unsigned         win_fill    = 0;
  smk_pkg::out_item_t  masked_bytes_q [$];

  int unsigned  error_count    = 0;
  int unsigned  cycle_count    = 0;
  int unsigned  send_idle_pct  = 35;
  int unsigned  recv_stall_pct = 56;
  int unsigned  hold_requests  = 0;
  int unsigned  holds_served   = 0;
  int unsigned  hold_left      = 0;

  stream_pattern_masker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic int unsigned active_len();
    if (pat_len_reg == 4'd0) return 1;
    if (pat_len_reg > 4'(WIN_DEPTH)) return WIN_DEPTH;
    return pat_len_reg;
  endfunction

  function automatic void drop_window(input int unsigned n);
    for (int unsigned k = 0; k + n < win_fill; k++) win_bytes[k] = win_bytes[k + n];
    win_fill -= n;
  endfunction

  // window decision for one transfer; appends the bytes it emits
  function automatic void apply_mask(input smk_pkg::in_item_t item);
    smk_pkg::out_item_t run_q [$];
    smk_pkg::out_item_t r;
    int unsigned        len;
    bit                 hit;
    len = active_len();
    r = '0;
    if (win_fill < WIN_DEPTH) begin
      win_bytes[win_fill] = item.data_byte;
      win_fill++;
    end
    while (win_fill >= len) begin
      hit = 1'b1;
      for (int unsigned k = 0; k < len; k++)
        if (win_bytes[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
      if (hit) begin
        r.out_byte = smk_pkg::STAR_BYTE;
        repeat (len) run_q.push_back(r);
        drop_window(len);
      end else begin
        r.out_byte = win_bytes[0];
        run_q.push_back(r);
        drop_window(1);
      end
    end
    if (item.end_of_stream) begin
      for (int unsigned k = 0; k < win_fill; k++) begin
        r.out_byte = win_bytes[k];
        run_q.push_back(r);
      end
      win_fill = 0;
      foreach (win_bytes[k]) win_bytes[k] = '0;
    end
    if (run_q.size() != 0) begin
      run_q[run_q.size()-1].last_of_run = 1'b1;
      run_q[run_q.size()-1].stream_done = item.end_of_stream;
    end
    foreach (run_q[k]) masked_bytes_q.push_back(run_q[k]);
  endfunction

  task automatic check_masked(input smk_pkg::out_item_t got);
    smk_pkg::out_item_t want;
    if (masked_bytes_q.size() == 0) begin
      report_error($sformatf("unexpected output byte %02h", got.out_byte));
      return;
    end
    want = masked_bytes_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_error($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    if (got.last_of_run !== want.last_of_run)
      report_error($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
    if (got.stream_done !== want.stream_done)
      report_error($sformatf("stream_done %b, want %b", got.stream_done, want.stream_done));
  endtask

  // output side: checks each transfer, drives random stalls and long hold-offs
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_masked(out_data_o);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    smk_pkg::in_item_t item;
    item.data_byte = b;
    item.end_of_stream = eos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_mask(item);
  endtask

  task automatic wait_quiet(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (masked_bytes_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_pattern(input logic [63:0] pbytes, input logic [63:0] len_word);
    wait_quiet(SETTLE_CYCLES);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= smk_pkg::CFG_PATTERN_BYTES;
    cfg_wdata_i <= pbytes;
    @(posedge clk_i);
    pat_bytes = pbytes;
    cfg_idx_i <= smk_pkg::CFG_PATTERN_LENGTH;
    cfg_wdata_i <= len_word;
    @(posedge clk_i);
    pat_len_reg = len_word[3:0];
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_pattern();
    logic [63:0] pb;
    logic [63:0] lw;
    int unsigned mode;
    pb = {$urandom, $urandom};
    mode = $urandom_range(9);
    if (mode == 0) pb = '0;
    else if (mode == 1) pb = '1;
    else if (mode < 6) begin
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(3))
          0: pb[8*k +: 8] = 8'h00;
          1: pb[8*k +: 8] = 8'hFF;
          2: pb[8*k +: 8] = 8'h61;
          default: pb[8*k +: 8] = 8'h62;
        endcase
      end
    end
    lw = {$urandom, $urandom};
    mode = $urandom_range(9);
    if (mode == 0) lw[3:0] = 4'd0;
    else if (mode == 1) lw[3:0] = 4'($urandom_range(9, 15));
    else if (mode == 2) lw[3:0] = 4'd8;
    else if (mode == 3) lw[3:0] = 4'd1;
    else lw[3:0] = 4'($urandom_range(1, 8));
    set_pattern(pb, lw);
  endtask

  // reset pattern is a single zero byte
  task automatic test_reset_pattern();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // full-width pattern, eight stars from one transfer, then a flush
  task automatic test_full_length_match();
    logic [63:0] pb;
    pb = 64'h80FF_007F_01FE_55AA;
    set_pattern(pb, 64'd8);
    for (int k = 0; k < 8; k++) send_byte(pb[8*k +: 8], 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
  endtask

  // length 15 clamps to 8; then length 0 (read as 1) mid-stream drains the window
  task automatic test_length_limits();
    logic [63:0] pb;
    pb = 64'h80FF_007F_01FE_55AA;
    set_pattern(pb, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int k = 0; k < 7; k++) send_byte(pb[8*k +: 8], 1'b0);
    set_pattern(64'h0000_0000_0000_00FE, 64'hFFFF_FFFF_FFFF_FFF0);
    send_byte(8'hFE, 1'b1);
  endtask

  // output held off while input keeps coming; block must fill and stall
  task automatic test_output_hold();
    send_idle_pct = 0;
    set_pattern(64'h0000_0000_0000_6261, 64'd2);
    hold_requests++;
    for (int k = 0; k < 40; k++) begin
      case ($urandom_range(2))
        0: send_byte(8'h61, k == 39);
        1: send_byte(8'h62, k == 39);
        default: send_byte(8'($urandom_range(255)), k == 39);
      endcase
    end
  endtask

  task automatic test_random_streams(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    logic [7:0]  text_q [$];
    int unsigned sent;
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    int unsigned cut;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_random_pattern();
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) load_random_pattern();
      target = $urandom_range(1, 24);
      text_q.delete();
      while (text_q.size() < target) begin
        len = active_len();
        pick = $urandom_range(99);
        if (pick < 35) begin
          for (int k = 0; k < len; k++) text_q.push_back(pat_bytes[8*k +: 8]);
        end else if (pick < 50) begin
          // broken occurrence: a prefix then a random byte
          cut = $urandom_range(0, len - 1);
          for (int k = 0; k < cut; k++) text_q.push_back(pat_bytes[8*k +: 8]);
          text_q.push_back(8'($urandom_range(255)));
        end else if (pick < 80) begin
          text_q.push_back(pat_bytes[8*$urandom_range(0, len - 1) +: 8]);
        end else begin
          text_q.push_back(8'($urandom_range(255)));
        end
      end
      foreach (text_q[i]) begin
        if (i != 0 && $urandom_range(49) == 0) load_random_pattern();
        send_byte(text_q[i], i == text_q.size() - 1);
        sent++;
      end
    end
  endtask

  initial begin
    foreach (win_bytes[k]) win_bytes[k] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_full_length_match();
    test_length_limits();
    test_output_hold();
    test_random_streams(35, 56, 40);
    test_random_streams(56, 35, 40);
    test_random_streams(0, 0, 40);
    wait_quiet(DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/smk_pkg.sv
rtl/smk_cfg.sv
rtl/smk_step.sv
rtl/stream_pattern_masker.sv
sim/stream_pattern_masker_test.sv
